// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ecal_pkg.sv =====
// Shared types and constants of the epoch to UTC calendar pipeline.
// No dependencies; imported by every RTL module of the block.
package ecal_pkg;

    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned SECS_W  = 17;   // seconds of the day, < 86400
    localparam int unsigned DQ_W    = 16;   // biased day count, < 49712
    localparam int unsigned Z_W     = 20;   // days since 0000-03-01
    localparam int unsigned DOE_W   = 18;   // day of era
    localparam int unsigned YOE_W   = 9;    // year of era
    localparam int unsigned DOY_W   = 9;    // day of March-based year
    localparam int unsigned MP_W    = 4;    // March-based month

    // 24856 whole days added in front so the floored split works unsigned
    localparam logic [EPOCH_W:0] DAY_BIAS_SECS = 33'd2147558400;
    // 719468 - 24856
    localparam logic [Z_W-1:0]   Z_BIAS        = 20'd694612;
    localparam logic [Z_W-1:0]   ERA4_START    = 20'd584388;
    localparam logic [Z_W-1:0]   ERA5_START    = 20'd730485;

    localparam logic [DOE_W-1:0] CENTURY_DAYS  = 18'd36524;
    localparam logic [DOE_W-1:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [DOY_W-1:0] MAR_TO_DEC    = 9'd306;
    localparam logic [MP_W-1:0]  MP_JANUARY    = 4'd10;

    // reciprocal multipliers, ceil(2^k / d), exact over each operand range
    localparam int unsigned      DIV675_SH   = 36;
    localparam logic [26:0]      DIV675_MUL  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
    localparam int unsigned      DIV3600_SH  = 30;
    localparam logic [18:0]      DIV3600_MUL = 19'(((64'd1 << 30) + 64'd3599) / 64'd3600);
    localparam int unsigned      DIV60_SH    = 18;
    localparam logic [12:0]      DIV60_MUL   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam int unsigned      DIV7_SH     = 23;
    localparam logic [20:0]      DIV7_MUL    = 21'(((64'd1 << 23) + 64'd6) / 64'd7);
    localparam int unsigned      DIV1460_SH  = 29;
    localparam logic [18:0]      DIV1460_MUL = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam int unsigned      DIV365_SH   = 27;
    localparam logic [18:0]      DIV365_MUL  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam int unsigned      DIV153_SH   = 19;
    localparam logic [11:0]      DIV153_MUL  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    // laid out as the output tdata, lowest field last
    typedef struct packed {
        logic [1:0] pad;
        logic [8:0] year_day;
        logic [7:0] year_since_1900;
        logic [3:0] month_index;
        logic [4:0] month_day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } result_t;

    // (153 * mp + 2) / 5: first day of each March-based month
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/ecal_day_split.sv =====
// Floored split of signed epoch seconds into days since 0000-03-01
// and seconds of the day, three register stages. Uses ecal_pkg.
module ecal_day_split (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [ecal_pkg::EPOCH_W-1:0] epoch_seconds,
    output logic                              out_valid,
    output logic [ecal_pkg::Z_W-1:0]          z,
    output logic [ecal_pkg::SECS_W-1:0]       secs
);
    import ecal_pkg::*;

    logic [2:0]        valid_reg, valid_next;
    logic [EPOCH_W:0]  u_reg, u_next;
    logic [25:0]       v_reg, v_next;
    logic [6:0]        lo_reg, lo_next;
    logic [DQ_W-1:0]   q_reg, q_next;
    logic [52:0]       q_prod;
    logic [25:0]       qd_prod;
    logic [25:0]       rem;
    logic [Z_W-1:0]    z_reg, z_next;
    logic [SECS_W-1:0] secs_reg, secs_next;

    assign valid_next = {valid_reg[1:0], in_valid};

    // stage 1: bias so the count is never negative
    assign u_next = {epoch_seconds[EPOCH_W-1], epoch_seconds} + DAY_BIAS_SECS;

    // stage 2: 86400 = 128 * 675, quotient by reciprocal
    assign q_prod = 53'(u_reg[EPOCH_W:7]) * 53'(DIV675_MUL);
    assign q_next = q_prod[DIV675_SH +: DQ_W];
    assign v_next = u_reg[EPOCH_W:7];
    assign lo_next = u_reg[6:0];

    // stage 3: remainder and day shift
    assign qd_prod   = 26'(q_reg) * 26'd675;
    assign rem       = v_reg - qd_prod;
    assign secs_next = {rem[9:0], lo_reg};
    assign z_next    = 20'(q_reg) + Z_BIAS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            q_reg    <= q_next;
            v_reg    <= v_next;
            lo_reg   <= lo_next;
            z_reg    <= z_next;
            secs_reg <= secs_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign z         = z_reg;
    assign secs      = secs_reg;

endmodule

// ===== src/ecal_tod.sv =====
// Hour, minute and second from the seconds of the day, four data stages.
// Uses ecal_pkg; valid bits travel in the enclosing pipeline.
module ecal_tod (
    input  logic                        clk,
    input  logic                        en,
    input  logic [ecal_pkg::SECS_W-1:0] secs,
    output ecal_pkg::tod_t              tod
);
    import ecal_pkg::*;

    logic [SECS_W-1:0] secs1_reg;
    logic [4:0]        hr1_reg, hr2_reg, hr3_reg, hr4_reg, hr1_next;
    logic [35:0]       hr_prod;
    logic [11:0]       rem2_reg, rem3_reg, rem2_next;
    logic [SECS_W-1:0] hr_secs;
    logic [SECS_W-1:0] rem_full;
    logic [24:0]       mi_prod;
    logic [5:0]        mi3_reg, mi4_reg, mi3_next;
    logic [11:0]       mi_secs;
    logic [11:0]       se_full;
    logic [5:0]        se4_reg, se4_next;

    assign hr_prod   = 36'(secs) * 36'(DIV3600_MUL);
    assign hr1_next  = hr_prod[DIV3600_SH +: 5];

    assign hr_secs   = 17'(hr1_reg) * 17'd3600;
    assign rem_full  = secs1_reg - hr_secs;
    assign rem2_next = rem_full[11:0];

    assign mi_prod   = 25'(rem2_reg) * 25'(DIV60_MUL);
    assign mi3_next  = mi_prod[DIV60_SH +: 6];

    assign mi_secs   = 12'(mi3_reg) * 12'd60;
    assign se_full   = rem3_reg - mi_secs;
    assign se4_next  = se_full[5:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            secs1_reg <= secs;
            hr1_reg   <= hr1_next;
            hr2_reg   <= hr1_reg;
            rem2_reg  <= rem2_next;
            hr3_reg   <= hr2_reg;
            rem3_reg  <= rem2_reg;
            mi3_reg   <= mi3_next;
            hr4_reg   <= hr3_reg;
            mi4_reg   <= mi3_reg;
            se4_reg   <= se4_next;
        end
    end

    assign tod.hour   = hr4_reg;
    assign tod.minute = mi4_reg;
    assign tod.second = se4_reg;

endmodule

// ===== src/ecal_civil.sv =====
// Civil date from days since 0000-03-01 (era method), eight stages,
// with weekday and the time of day alongside. Uses ecal_pkg and ecal_tod.
module ecal_civil (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ecal_pkg::Z_W-1:0]    z,
    input  logic [ecal_pkg::SECS_W-1:0] secs,
    output logic                        out_valid,
    output ecal_pkg::result_t           result
);
    import ecal_pkg::*;

    logic [7:0] valid_reg, valid_next;

    // stage 1
    logic             era1_reg, era1_next;
    logic [DOE_W-1:0] doe1_reg, doe1_next;
    logic [Z_W-1:0]   zp1_reg, zp1_next;
    logic [Z_W-1:0]   z_off;
    // stage 2
    logic [36:0]      n1_prod;
    logic [6:0]       n1_2_reg, n1_2_next;
    logic [2:0]       c2_reg, c2_next;
    logic             e2_reg, e2_next;
    logic [40:0]      w_prod;
    logic [17:0]      wq2_reg, wq2_next;
    logic [DOE_W-1:0] doe2_reg;
    logic             era2_reg;
    logic [Z_W-1:0]   zp2_reg;
    // stage 3
    logic [DOE_W-1:0] a3_reg, a3_next;
    logic [Z_W-1:0]   w_rem;
    logic [2:0]       wd3_reg, wd3_next;
    logic [DOE_W-1:0] doe3_reg;
    logic             era3_reg;
    // stage 4
    logic [36:0]      yoe_prod;
    logic [YOE_W-1:0] yoe4_reg, yoe4_next;
    logic [DOE_W-1:0] doe4_reg;
    logic             era4_reg;
    logic [2:0]       wd4_reg;
    // stage 5
    logic [1:0]       cent5;
    logic [DOE_W-1:0] yr_days;
    logic [DOE_W-1:0] doy_full;
    logic [DOY_W-1:0] doy5_reg, doy5_next;
    logic [YOE_W-1:0] yoe5_reg;
    logic             era5_reg;
    logic [2:0]       wd5_reg;
    tod_t             tod_now;
    tod_t             tod5_reg, tod6_reg, tod7_reg;
    // stage 6
    logic [10:0]      mp_arg;
    logic [22:0]      mp_prod;
    logic [MP_W-1:0]  mp6_reg, mp6_next;
    logic [DOY_W-1:0] doy6_reg;
    logic [YOE_W-1:0] yoe6_reg;
    logic             era6_reg;
    logic [2:0]       wd6_reg;
    // stage 7
    logic [DOY_W-1:0] dom_full;
    logic [4:0]       dom7_reg, dom7_next;
    logic [MP_W-1:0]  mon7_reg, mon7_next;
    logic [YOE_W-1:0] yp7_reg, yp7_next;
    logic [DOY_W-1:0] doy7_reg;
    logic             era7_reg;
    logic [2:0]       wd7_reg;
    // stage 8
    logic             leap;
    logic [DOY_W-1:0] yday;
    logic [YOE_W-1:0] ysince_full;
    result_t          res8_reg, res8_next;

    assign valid_next = {valid_reg[6:0], in_valid};

    ecal_tod u_tod (
        .clk  (clk),
        .en   (en),
        .secs (secs),
        .tod  (tod_now)
    );

    // stage 1: era is 4 or 5 over the whole 32-bit input range
    assign era1_next = (z >= ERA5_START);
    assign z_off     = era1_next ? (z - ERA5_START) : (z - ERA4_START);
    assign doe1_next = z_off[DOE_W-1:0];
    assign zp1_next  = z + 20'd3;

    // stage 2
    assign n1_prod   = 37'(doe1_reg) * 37'(DIV1460_MUL);
    assign n1_2_next = n1_prod[DIV1460_SH +: 7];
    always_comb
    begin
        if (doe1_reg >= ERA_LAST_DAY)
            c2_next = 3'd4;
        else if (doe1_reg >= 18'(CENTURY_DAYS * 3))
            c2_next = 3'd3;
        else if (doe1_reg >= 18'(CENTURY_DAYS * 2))
            c2_next = 3'd2;
        else if (doe1_reg >= CENTURY_DAYS)
            c2_next = 3'd1;
        else
            c2_next = 3'd0;
    end
    assign e2_next  = (doe1_reg == ERA_LAST_DAY);
    assign w_prod   = 41'(zp1_reg) * 41'(DIV7_MUL);
    assign wq2_next = w_prod[DIV7_SH +: 18];

    // stage 3
    assign a3_next  = doe2_reg - 18'(n1_2_reg) + 18'(c2_reg) - 18'(e2_reg);
    assign w_rem    = zp2_reg - 20'(wq2_reg) * 20'd7;
    assign wd3_next = w_rem[2:0];

    // stage 4
    assign yoe_prod  = 37'(a3_reg) * 37'(DIV365_MUL);
    assign yoe4_next = yoe_prod[DIV365_SH +: YOE_W];

    // stage 5
    always_comb
    begin
        if (yoe4_reg >= 9'd300)
            cent5 = 2'd3;
        else if (yoe4_reg >= 9'd200)
            cent5 = 2'd2;
        else if (yoe4_reg >= 9'd100)
            cent5 = 2'd1;
        else
            cent5 = 2'd0;
    end
    assign yr_days   = 18'(yoe4_reg) * 18'd365 + 18'(yoe4_reg[YOE_W-1:2]) - 18'(cent5);
    assign doy_full  = doe4_reg - yr_days;
    assign doy5_next = doy_full[DOY_W-1:0];

    // stage 6
    assign mp_arg   = 11'(doy5_reg) * 11'd5 + 11'd2;
    assign mp_prod  = 23'(mp_arg) * 23'(DIV153_MUL);
    assign mp6_next = mp_prod[DIV153_SH +: MP_W];

    // stage 7
    assign dom_full  = doy6_reg - month_start(mp6_reg) + 9'd1;
    assign dom7_next = dom_full[4:0];
    assign mon7_next = (mp6_reg < MP_JANUARY) ? (mp6_reg + 4'd2) : (mp6_reg - MP_JANUARY);
    // January and February belong to the next civil year
    assign yp7_next  = yoe6_reg + 9'(mon7_next <= 4'd1);

    // stage 8: year base is 1600 or 2000, so only the year of era matters
    assign leap = (yp7_reg[1:0] == 2'd0) && (yp7_reg != 9'd100) &&
                  (yp7_reg != 9'd200) && (yp7_reg != 9'd300);
    assign yday = (doy7_reg >= MAR_TO_DEC) ? (doy7_reg - MAR_TO_DEC)
                                           : (doy7_reg + 9'd59 + 9'(leap));
    assign ysince_full = era7_reg ? (yp7_reg + 9'd100) : (yp7_reg - 9'd300);

    always_comb
    begin
        res8_next.pad             = 2'b00;
        res8_next.year_day        = yday;
        res8_next.year_since_1900 = ysince_full[7:0];
        res8_next.month_index     = mon7_reg;
        res8_next.month_day       = dom7_reg;
        res8_next.weekday         = wd7_reg;
        res8_next.hour            = tod7_reg.hour;
        res8_next.minute          = tod7_reg.minute;
        res8_next.second          = tod7_reg.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            era1_reg <= era1_next;
            doe1_reg <= doe1_next;
            zp1_reg  <= zp1_next;

            n1_2_reg <= n1_2_next;
            c2_reg   <= c2_next;
            e2_reg   <= e2_next;
            wq2_reg  <= wq2_next;
            doe2_reg <= doe1_reg;
            era2_reg <= era1_reg;
            zp2_reg  <= zp1_reg;

            a3_reg   <= a3_next;
            wd3_reg  <= wd3_next;
            doe3_reg <= doe2_reg;
            era3_reg <= era2_reg;

            yoe4_reg <= yoe4_next;
            doe4_reg <= doe3_reg;
            era4_reg <= era3_reg;
            wd4_reg  <= wd3_reg;

            doy5_reg <= doy5_next;
            yoe5_reg <= yoe4_reg;
            era5_reg <= era4_reg;
            wd5_reg  <= wd4_reg;
            tod5_reg <= tod_now;

            mp6_reg  <= mp6_next;
            doy6_reg <= doy5_reg;
            yoe6_reg <= yoe5_reg;
            era6_reg <= era5_reg;
            wd6_reg  <= wd5_reg;
            tod6_reg <= tod5_reg;

            dom7_reg <= dom7_next;
            mon7_reg <= mon7_next;
            yp7_reg  <= yp7_next;
            doy7_reg <= doy6_reg;
            era7_reg <= era6_reg;
            wd7_reg  <= wd6_reg;
            tod7_reg <= tod6_reg;

            res8_reg <= res8_next;
        end
    end

    assign out_valid = valid_reg[7];
    assign result    = res8_reg;

endmodule

// ===== src/ecal_out_buf.sv =====
// Output register plus one skid entry; freezes the pipeline only when
// the skid entry is occupied. Uses ecal_pkg for the result type.
module ecal_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ecal_pkg::result_t in_data,
    output logic              pipe_en,
    output logic              out_valid,
    input  logic              out_ready,
    output ecal_pkg::result_t out_data
);
    import ecal_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;
    logic    load_out;
    logic    load_skid;
    logic    take_skid;

    assign pipe_en = !skid_valid_reg;
    assign push    = pipe_en && in_valid;
    assign pop     = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        take_skid       = 1'b0;
        if (pop || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                take_skid       = 1'b1;
            end
            else
            begin
                out_valid_next = push;
                load_out       = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_skid)
            out_data_reg <= skid_data_reg;
        else if (load_out)
            out_data_reg <= in_data;
        if (load_skid)
            skid_data_reg <= in_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== src/epoch_seconds_to_utc_calendar_top.sv =====
// channel | direction | tdata fields (low bit first)                     | tuser
// s_axis  | in        | epoch_seconds[31:0]                              | -
// m_axis  | out       | second, minute, hour, weekday, month_day,        | -
//         |           | month_index, year_since_1900, year_day, 2b zero  |
//
// One item per cycle while s_axis_tready stays high; 12 register stages (3 day-split,
// 8 calendar, output register) lie between s_axis and m_axis.
// Reset clears all valid bits and the output/skid flags; no data is cleared.
// A stalled output parks one more item in the skid entry; s_axis_tready drops
// only while that entry is full, and the whole pipeline holds in place then.
// Top level of the epoch to UTC calendar converter; uses ecal_pkg,
// ecal_day_split, ecal_civil and ecal_out_buf.
module epoch_seconds_to_utc_calendar_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] epoch_seconds
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [5:0] second, [11:6] minute, [16:12] hour,
                                        // [19:17] weekday, [24:20] month_day,
                                        // [28:25] month_index, [36:29] year_since_1900,
                                        // [45:37] year_day, [47:46] zero
);
    import ecal_pkg::*;

    logic              pipe_en;
    logic              split_valid;
    logic [Z_W-1:0]    split_z;
    logic [SECS_W-1:0] split_secs;
    logic              civil_valid;
    result_t           civil_result;
    result_t           out_result;

    assign s_axis_tready = pipe_en;

    ecal_day_split u_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_valid      (s_axis_tvalid),
        .epoch_seconds ($signed(s_axis_tdata)),
        .out_valid     (split_valid),
        .z             (split_z),
        .secs          (split_secs)
    );

    ecal_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (split_valid),
        .z         (split_z),
        .secs      (split_secs),
        .out_valid (civil_valid),
        .result    (civil_result)
    );

    ecal_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (civil_valid),
        .in_data   (civil_result),
        .pipe_en   (pipe_en),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = out_result;

endmodule

// ===== src/ecal_checker.sv =====
// Port-level checks of the epoch to UTC calendar converter, bound to the
// top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module ecal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // a result held back by the sink stays put
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output item changed")

    // every field of a result but year_since_1900 is a legal calendar value
    `ASSERT_IMPLIES(a_field_range, m_axis_tvalid, (m_axis_tdata[5:0] < 6'd60) && (m_axis_tdata[11:6] < 6'd60) && (m_axis_tdata[16:12] < 5'd24) && (m_axis_tdata[19:17] < 3'd7) && (m_axis_tdata[24:20] != 5'd0) && (m_axis_tdata[28:25] < 4'd12) && (m_axis_tdata[45:37] < 9'd366) && (m_axis_tdata[47:46] == 2'b00), "result field out of range")

    // in January the day of year follows the day of month
    `ASSERT_IMPLIES(a_january_day, m_axis_tvalid && (m_axis_tdata[28:25] == 4'd0), (m_axis_tdata[45:37] + 9'd1) == m_axis_tdata[24:20], "January day of year mismatch")

    // input side backs off only behind a result the sink refused
    `ASSERT_IMPLIES(a_ready_drop, !s_axis_tready, m_axis_tvalid && !$past(m_axis_tready), "input stalled without output backpressure")

endmodule

bind epoch_seconds_to_utc_calendar_top ecal_checker u_ecal_checker (.*);
